>>> rtl/idm_pkg.sv
// ----------------------------------------------------------------------------
// idm_pkg
// Shared widths, constants and types of the image difference metrics block.
// ----------------------------------------------------------------------------
package idm_pkg;

    localparam int PIXEL_COUNT_BITS = 28;
    localparam int FRACTION_BITS    = 8;

    localparam int CH_W    = 8;
    localparam int CNT_W   = PIXEL_COUNT_BITS + 1;
    localparam int SQ_W    = 46;
    localparam int ABS_W   = 38;
    localparam int DEN_W   = CNT_W + 2;
    localparam int DIV_W   = SQ_W + FRACTION_BITS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int MSE_W  = 24;
    localparam int MAE_W  = 16;
    localparam int PCT_W  = 15;
    localparam int PSNR_W = 15;

    localparam int LOG_W    = 48;
    localparam int MANT_W   = 31;
    localparam int K_W      = 6;
    localparam int LFRAC_W  = 16;
    localparam int LOGQ_W   = K_W + LFRAC_W;
    localparam int LIT_W    = 4;

    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);

    localparam logic [CH_W-1:0]   THRESH_RESET      = 8'd2;
    localparam logic [PSNR_W-1:0] PSNR_CAP          = PSNR_W'(99 << FRACTION_BITS);
    localparam logic [17:0]       TEN_LOG10_TWO_Q16 = 18'd197283;
    localparam logic [17:0]       PEAK_SCALE        = 18'd195075;
    localparam logic [6:0]        PERCENT           = 7'd100;

    typedef struct packed {
        logic [CH_W-1:0]  worst;
        logic [CNT_W-1:0] over;
        logic [CNT_W-1:0] pixels;
        logic [SQ_W-1:0]  sq;
        logic [ABS_W-1:0] abs_sum;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic              done;
        logic [LOGQ_W-1:0] value;
    } t_log_rsp;

endpackage

>>> rtl/idm_front.sv
// ----------------------------------------------------------------------------
// idm_front
// Per-pixel channel differences and frame accumulators; pushes frame totals.
// ----------------------------------------------------------------------------
module idm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  i_fifo_full,
    input  logic [7:0]            i_first_red,
    input  logic [7:0]            i_first_green,
    input  logic [7:0]            i_first_blue,
    input  logic [7:0]            i_second_red,
    input  logic [7:0]            i_second_green,
    input  logic [7:0]            i_second_blue,
    input  logic                  i_last_pixel,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    output logic                  o_wr_en,
    output idm_pkg::t_frame       o_wr_data
);
    import idm_pkg::*;

    logic [CH_W-1:0]  r_thresh;
    logic [CNT_W-1:0] r_pix, n_pix;
    logic [CNT_W-1:0] r_over, n_over;
    logic [SQ_W-1:0]  r_sq, n_sq;
    logic [ABS_W-1:0] r_abs, n_abs;
    logic [CH_W-1:0]  r_worst, n_worst;
    logic [CH_W-1:0]  e_r, e_g, e_b, worst;
    logic [17:0]      sq_sum;
    logic [9:0]       abs_sum;
    logic             active, accept;

    function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    always_comb begin
        e_r     = absdiff(i_first_red, i_second_red);
        e_g     = absdiff(i_first_green, i_second_green);
        e_b     = absdiff(i_first_blue, i_second_blue);
        worst   = (e_r > e_g) ? e_r : e_g;
        worst   = (e_b > worst) ? e_b : worst;
        sq_sum  = 18'(e_r * e_r) + 18'(e_g * e_g) + 18'(e_b * e_b);
        abs_sum = 10'(e_r) + 10'(e_g) + 10'(e_b);
        // stop counting once the frame hits its pixel limit
        active  = !r_pix[CNT_W-1];
        n_pix   = r_pix;
        n_over  = r_over;
        n_sq    = r_sq;
        n_abs   = r_abs;
        n_worst = r_worst;
        if (active) begin
            n_pix = r_pix + 1'b1;
            n_sq  = r_sq + SQ_W'(sq_sum);
            n_abs = r_abs + ABS_W'(abs_sum);
            if (worst > r_worst) n_worst = worst;
            if (worst > r_thresh) n_over = r_over + 1'b1;
        end
    end

    assign accept    = push && !i_fifo_full;
    assign o_wr_en   = accept && i_last_pixel;
    assign o_wr_data = '{worst: n_worst, over: n_over, pixels: n_pix,
                         sq: n_sq, abs_sum: n_abs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_pix    <= '0;
            r_over   <= '0;
            r_sq     <= '0;
            r_abs    <= '0;
            r_worst  <= '0;
        end else begin
            if (i_cfg_wr_en) r_thresh <= i_cfg_wr_data;
            if (accept) begin
                if (i_last_pixel) begin
                    r_pix   <= '0;
                    r_over  <= '0;
                    r_sq    <= '0;
                    r_abs   <= '0;
                    r_worst <= '0;
                end else begin
                    r_pix   <= n_pix;
                    r_over  <= n_over;
                    r_sq    <= n_sq;
                    r_abs   <= n_abs;
                    r_worst <= n_worst;
                end
            end
        end
    end

endmodule

>>> rtl/idm_fifo.sv
// ----------------------------------------------------------------------------
// idm_fifo
// Short queue of frame totals between the accumulator and the result engine.
// ----------------------------------------------------------------------------
module idm_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  idm_pkg::t_frame       i_wr_data,
    input  logic                  i_rd_en,
    output idm_pkg::t_frame       o_rd_data,
    output idm_pkg::t_fifo_stat   o_stat
);
    import idm_pkg::*;

    t_frame              r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FPTR_W:0]     r_count;
    logic                do_wr, do_rd;

    assign o_stat.full  = (r_count == (FPTR_W+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rd_data    = r_mem[r_rd_ptr];
    assign do_wr        = i_wr_en && !o_stat.full;
    assign do_rd        = i_rd_en && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wr_ptr] <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_wr && !do_rd) r_count <= r_count + 1'b1;
            else if (do_rd && !do_wr) r_count <= r_count - 1'b1;
        end
    end

endmodule

>>> rtl/idm_div.sv
// ----------------------------------------------------------------------------
// idm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module idm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [idm_pkg::DIV_W-1:0]   i_dividend,
    input  logic [idm_pkg::DEN_W-1:0]   i_divisor,
    output idm_pkg::t_div_rsp           o_rsp
);
    import idm_pkg::*;

    logic                 r_busy, r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_rem, r_den;
    logic [DEN_W:0]       rem_sh, rem_sub;
    logic                 ge;

    always_comb begin
        rem_sh  = {r_rem, r_num[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits shift in the bottom
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], ge};
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

endmodule

>>> rtl/idm_log2.sv
// ----------------------------------------------------------------------------
// idm_log2
// log2 in Q.16: serial normalize, then 16 mantissa squaring steps.
// ----------------------------------------------------------------------------
module idm_log2 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [idm_pkg::LOG_W-1:0]   i_value,
    output idm_pkg::t_log_rsp           o_rsp
);
    import idm_pkg::*;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_MUL  = 2'd2;
    localparam logic [1:0] L_SQR  = 2'd3;

    logic [1:0]          r_state;
    logic                r_done;
    logic [LOG_W-1:0]    r_val;
    logic [K_W-1:0]      r_k;
    logic [MANT_W-1:0]   r_x;
    logic [2*MANT_W-1:0] r_sq;
    logic [LFRAC_W-1:0]  r_frac;
    logic [LIT_W-1:0]    r_it;
    logic [MANT_W:0]     t;

    assign t           = r_sq[2*MANT_W-1:MANT_W-1];
    assign o_rsp.done  = r_done;
    assign o_rsp.value = {r_k, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: if (i_start) r_state <= L_NORM;
                L_NORM: if (r_val[LOG_W-1]) r_state <= L_MUL;
                L_MUL:  r_state <= L_SQR;
                L_SQR: begin
                    if (r_it == '1) begin
                        r_state <= L_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= L_MUL;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_val <= i_value;
                r_k   <= K_W'(LOG_W - 1);
            end
            L_NORM: begin
                if (r_val[LOG_W-1]) begin
                    r_x    <= r_val[LOG_W-1 -: MANT_W];
                    r_it   <= '0;
                    r_frac <= '0;
                end else begin
                    r_val <= r_val << 1;
                    r_k   <= r_k - 1'b1;
                end
            end
            L_MUL: r_sq <= r_x * r_x;
            L_SQR: begin
                r_it <= r_it + 1'b1;
                // mantissa reached 2.0: halve it and emit a one
                if (t[MANT_W]) begin
                    r_x    <= t[MANT_W:1];
                    r_frac <= {r_frac[LFRAC_W-2:0], 1'b1};
                end else begin
                    r_x    <= t[MANT_W-1:0];
                    r_frac <= {r_frac[LFRAC_W-2:0], 1'b0};
                end
            end
            default: r_val <= r_val;
        endcase
    end

endmodule

>>> rtl/idm_back.sv
// ----------------------------------------------------------------------------
// idm_back
// Per-frame result engine: means, percentage and PSNR; holds the result word.
// ----------------------------------------------------------------------------
module idm_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  idm_pkg::t_frame              i_frame,
    input  idm_pkg::t_fifo_stat          i_fifo_stat,
    output logic                         o_rd_en,
    input  logic                         pop,
    output logic                         empty,
    output logic [7:0]                   o_max_channel_error,
    output logic [28:0]                  o_differing_pixels,
    output logic [28:0]                  o_frame_pixels,
    output logic [45:0]                  o_squared_error_sum,
    output logic [37:0]                  o_absolute_error_sum,
    output logic [23:0]                  o_mean_squared_error,
    output logic [15:0]                  o_mean_absolute_error,
    output logic [14:0]                  o_differing_percent,
    output logic [14:0]                  o_peak_snr
);
    import idm_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MSE   = 4'd1;
    localparam logic [3:0] ST_MAE   = 4'd2;
    localparam logic [3:0] ST_PCT   = 4'd3;
    localparam logic [3:0] ST_SCALE = 4'd4;
    localparam logic [3:0] ST_LOGN  = 4'd5;
    localparam logic [3:0] ST_LOGSQ = 4'd6;
    localparam logic [3:0] ST_PMUL  = 4'd7;
    localparam logic [3:0] ST_PFIN  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam int PROD_W = LOGQ_W + 18;
    localparam int P_W    = PROD_W - (32 - FRACTION_BITS) + 1;

    logic [3:0]          r_state;
    logic                r_wait, r_out_valid;
    t_frame              r_frame;
    logic [DEN_W-1:0]    r_den3;
    logic [CNT_W+6:0]    r_over100;
    logic [MSE_W-1:0]    r_mse;
    logic [MAE_W-1:0]    r_mae;
    logic [PCT_W-1:0]    r_pct;
    logic [PSNR_W-1:0]   r_psnr;
    logic [LOG_W-1:0]    r_lognum;
    logic [LOGQ_W-1:0]   r_ln, r_ld;
    logic [PROD_W-1:0]   r_prod;

    logic                div_start, log_start, load_out;
    logic [DIV_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic [LOG_W-1:0]    log_val;
    logic [P_W-1:0]      p_round;
    t_div_rsp            div_rsp;
    t_log_rsp            log_rsp;

    idm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_rsp      (div_rsp)
    );

    idm_log2 u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_value (log_val),
        .o_rsp   (log_rsp)
    );

    // round half up: add half the divisor before dividing
    always_comb begin
        div_num = '0;
        div_den = r_den3;
        case (r_state)
            ST_MSE: div_num = (DIV_W'(r_frame.sq) << FRACTION_BITS)
                              + DIV_W'(r_den3 >> 1);
            ST_MAE: div_num = (DIV_W'(r_frame.abs_sum) << FRACTION_BITS)
                              + DIV_W'(r_den3 >> 1);
            ST_PCT: begin
                div_num = (DIV_W'(r_over100) << FRACTION_BITS)
                          + DIV_W'(r_frame.pixels >> 1);
                div_den = DEN_W'(r_frame.pixels);
            end
            default: div_num = '0;
        endcase
    end

    assign div_start = !r_wait &&
                       (r_state == ST_MSE || r_state == ST_MAE || r_state == ST_PCT);
    assign log_start = !r_wait && (r_state == ST_LOGN || r_state == ST_LOGSQ);
    assign log_val   = (r_state == ST_LOGN) ? r_lognum : LOG_W'(r_frame.sq);
    assign o_rd_en   = (r_state == ST_IDLE) && !i_fifo_stat.empty;
    assign load_out  = (r_state == ST_OUT) && (!r_out_valid || pop);
    assign p_round   = P_W'((r_prod + (PROD_W'(1) << (31 - FRACTION_BITS)))
                            >> (32 - FRACTION_BITS));
    assign empty     = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (div_start || log_start) r_wait <= 1'b1;
            if (div_rsp.done || log_rsp.done) r_wait <= 1'b0;
            if (load_out) r_out_valid <= 1'b1;
            else if (pop) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE:  if (o_rd_en) r_state <= ST_MSE;
                ST_MSE:   if (div_rsp.done) r_state <= ST_MAE;
                ST_MAE:   if (div_rsp.done) r_state <= ST_PCT;
                ST_PCT: begin
                    if (div_rsp.done)
                        r_state <= (r_frame.sq == '0) ? ST_OUT : ST_SCALE;
                end
                ST_SCALE: r_state <= ST_LOGN;
                ST_LOGN:  if (log_rsp.done) r_state <= ST_LOGSQ;
                ST_LOGSQ: if (log_rsp.done) r_state <= ST_PMUL;
                ST_PMUL:  r_state <= ST_PFIN;
                ST_PFIN:  r_state <= ST_OUT;
                ST_OUT:   if (load_out) r_state <= ST_IDLE;
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_frame   <= i_frame;
                r_den3    <= (DEN_W'(i_frame.pixels) << 1) + DEN_W'(i_frame.pixels);
                r_over100 <= i_frame.over * PERCENT;
                r_psnr    <= PSNR_CAP;
            end
            ST_MSE: begin
                if (div_rsp.done)
                    r_mse <= (div_rsp.quot[DIV_W-1:MSE_W] != '0) ? '1
                             : div_rsp.quot[MSE_W-1:0];
            end
            ST_MAE: begin
                if (div_rsp.done)
                    r_mae <= (div_rsp.quot[DIV_W-1:MAE_W] != '0) ? '1
                             : div_rsp.quot[MAE_W-1:0];
            end
            ST_PCT: begin
                if (div_rsp.done)
                    r_pct <= (div_rsp.quot[DIV_W-1:PCT_W] != '0) ? '1
                             : div_rsp.quot[PCT_W-1:0];
            end
            ST_SCALE: r_lognum <= LOG_W'(r_frame.pixels * PEAK_SCALE);
            ST_LOGN:  if (log_rsp.done) r_ln <= log_rsp.value;
            ST_LOGSQ: if (log_rsp.done) r_ld <= log_rsp.value;
            ST_PMUL: begin
                // error log at or above the peak log gives zero
                if (r_ld >= r_ln) r_prod <= '0;
                else r_prod <= (r_ln - r_ld) * TEN_LOG10_TWO_Q16;
            end
            ST_PFIN: r_psnr <= (p_round > P_W'(PSNR_CAP)) ? PSNR_CAP
                               : p_round[PSNR_W-1:0];
            default: r_prod <= r_prod;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_max_channel_error   <= r_frame.worst;
            o_differing_pixels    <= r_frame.over;
            o_frame_pixels        <= r_frame.pixels;
            o_squared_error_sum   <= r_frame.sq;
            o_absolute_error_sum  <= r_frame.abs_sum;
            o_mean_squared_error  <= r_mse;
            o_mean_absolute_error <= r_mae;
            o_differing_percent   <= r_pct;
            o_peak_snr            <= r_psnr;
        end
    end

endmodule

>>> rtl/image_difference_metrics.sv
// ----------------------------------------------------------------------------
// image_difference_metrics
// Pixel-pair error statistics with per-frame MSE, MAE, percent and PSNR.
// ----------------------------------------------------------------------------
//  channel   handshake          word
//  -------   ----------------   ------------------------------------------
//  pixel     push / full        two RGB pixels and last_pixel flag
//  result    empty / pop        frame totals and four Q.8 metrics
//  config    i_cfg_wr_en        diff_threshold, 8 bits
//
//  One pixel pair is taken per cycle while full is low; each pair is
//  accumulated in the cycle it is taken. A frame result shows after its
//  last pixel once three serial divides, two log2 passes and the hand-off
//  are done; a zero-error frame skips the logs.
//  Up to two finished frames wait in the queue; full rises only when both
//  slots are taken. Synchronous active-low reset clears all accumulators.
// ----------------------------------------------------------------------------
module image_difference_metrics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_first_red,
    input  logic [7:0]  i_first_green,
    input  logic [7:0]  i_first_blue,
    input  logic [7:0]  i_second_red,
    input  logic [7:0]  i_second_green,
    input  logic [7:0]  i_second_blue,
    input  logic        i_last_pixel,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_max_channel_error,
    output logic [28:0] o_differing_pixels,
    output logic [28:0] o_frame_pixels,
    output logic [45:0] o_squared_error_sum,
    output logic [37:0] o_absolute_error_sum,
    output logic [23:0] o_mean_squared_error,
    output logic [15:0] o_mean_absolute_error,
    output logic [14:0] o_differing_percent,
    output logic [14:0] o_peak_snr
);
    import idm_pkg::*;

    logic       wr_en, rd_en;
    t_frame     wr_data, rd_data;
    t_fifo_stat fifo_stat;

    assign full = fifo_stat.full;

    idm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .i_fifo_full    (fifo_stat.full),
        .i_first_red    (i_first_red),
        .i_first_green  (i_first_green),
        .i_first_blue   (i_first_blue),
        .i_second_red   (i_second_red),
        .i_second_green (i_second_green),
        .i_second_blue  (i_second_blue),
        .i_last_pixel   (i_last_pixel),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_wr_en        (wr_en),
        .o_wr_data      (wr_data)
    );

    idm_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .o_rd_data (rd_data),
        .o_stat    (fifo_stat)
    );

    idm_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_frame               (rd_data),
        .i_fifo_stat           (fifo_stat),
        .o_rd_en               (rd_en),
        .pop                   (pop),
        .empty                 (empty),
        .o_max_channel_error   (o_max_channel_error),
        .o_differing_pixels    (o_differing_pixels),
        .o_frame_pixels        (o_frame_pixels),
        .o_squared_error_sum   (o_squared_error_sum),
        .o_absolute_error_sum  (o_absolute_error_sum),
        .o_mean_squared_error  (o_mean_squared_error),
        .o_mean_absolute_error (o_mean_absolute_error),
        .o_differing_percent   (o_differing_percent),
        .o_peak_snr            (o_peak_snr)
    );

endmodule

>>> rtl/idm_checker.sv
// ----------------------------------------------------------------------------
// idm_checker
// Port-level checks on the result queue of image_difference_metrics.
// ----------------------------------------------------------------------------
module idm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [28:0] o_differing_pixels,
    input logic [28:0] o_frame_pixels,
    input logic [14:0] o_differing_percent,
    input logic [14:0] o_peak_snr
);
    import idm_pkg::*;

    // no result may appear straight out of reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // a waiting word holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_peak_snr)
                              && $stable(o_frame_pixels)))
        else $error("result changed before pop");

    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_differing_pixels <= o_frame_pixels && o_frame_pixels != '0))
        else $error("differing count exceeds frame count");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_peak_snr <= PSNR_CAP && o_differing_percent <= 15'd25600))
        else $error("metric out of range");

endmodule

bind image_difference_metrics idm_checker u_idm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .empty               (empty),
    .pop                 (pop),
    .o_differing_pixels  (o_differing_pixels),
    .o_frame_pixels      (o_frame_pixels),
    .o_differing_percent (o_differing_percent),
    .o_peak_snr          (o_peak_snr)
);
